// ===== hdl/h264_rtp_nal_reassembler_assert.svh =====
// Assertion macros for the reassembler's top-level RTL.
`ifndef H264_RTP_NAL_REASSEMBLER_ASSERT_SVH
`define H264_RTP_NAL_REASSEMBLER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HNR_ASSERT_SAME(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("hnr assertion failed");

// Check that a condition implies another in the next cycle.
`define HNR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("hnr assertion failed");

`endif

// ===== hdl/hnr_pkg.sv =====
`default_nettype none
package hnr_pkg;

  // Input item: one RTP payload byte with its marks
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] seq_number;
    logic        packet_first;
    logic        packet_last;
    logic        frame_first;
    logic        frame_last;
  } in_t;

  // Result item: stream byte or frame-end report
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_done;
    logic [1:0] error_code;
  } out_t;

  // Command from front to back: start code, data byte, frame end
  typedef struct packed {
    logic       start_code;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_done;
    logic [1:0] error_code;
  } cmd_t;

  localparam logic [4:0] TYPE_STAP_A = 5'd24;
  localparam logic [4:0] TYPE_FU_A   = 5'd28;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_STAP   = 2'd1;
  localparam logic [1:0] KIND_FU     = 2'd2;
  localparam logic [1:0] KIND_DROP   = 2'd3;

  localparam logic [1:0] PHASE_SIZE_HI = 2'd0;
  localparam logic [1:0] PHASE_SIZE_LO = 2'd1;
  localparam logic [1:0] PHASE_HEADER  = 2'd2;
  localparam logic [1:0] PHASE_BODY    = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN = 2'd1;
  localparam logic [1:0] ERR_TYPE    = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/h264_rtp_nal_reassembler.sv =====
// H.264 RTP payload to Annex B byte stream.
// Input channel: in_data carries one payload byte with its sequence number
// and packet/frame marks; it is taken at a clock edge with in_push high and
// in_full low. Result channel: out_data shows the oldest waiting item while
// out_empty is low; out_pop high at a clock edge takes it.
// Configuration: cfg_we writes cfg_data into the start code length select
// (0 four bytes, 1 three bytes); write it only while the block is idle.
// Throughput: one input byte per cycle while the command queue has room.
// Each input byte becomes at most one queued command; while out_pop is high
// the output side plays it out at one item per cycle: up to 4 start code
// bytes, one data byte and one frame-end item. Commands are registered in
// the queue and reach out_data in order, after the older commands.
// When the receiver stalls, the queue (QUEUE_DEPTH commands) fills and then
// in_full rises; no request is lost.
// Reset clears the packet state, the sticky error, the queue and the start
// code select (four-byte start code).
`default_nettype none
module h264_rtp_nal_reassembler #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire hnr_pkg::in_t in_data,
  output logic              out_empty,
  input  wire logic         out_pop,
  output hnr_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [CW-1:0] q_count;
  hnr_pkg::cmd_t q_in;
  hnr_pkg::cmd_t q_head;

  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign out_empty = q_empty;

  hnr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cmd_valid (q_push),
    .cmd       (q_in)
  );

  hnr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty),
    .count     (q_count)
  );

  hnr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head       (q_head),
    .head_valid (!q_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .head_done  (q_pop)
  );

`include "h264_rtp_nal_reassembler_assert.svh"

  // Queue never holds more than its depth
  `HNR_ASSERT_SAME(a_count_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH))
  // A command is queued only when there is room
  `HNR_ASSERT_SAME(a_push_room, q_push, !q_full)
  // A popped item that is not the command's last keeps a result waiting
  `HNR_ASSERT_NEXT(a_head_holds, out_pop && !q_empty && !q_pop, !out_empty)

endmodule
`default_nettype wire

// ===== hdl/hnr_front.sv =====
`default_nettype none
module hnr_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire hnr_pkg::in_t in_data,
  output logic              cmd_valid,
  output hnr_pkg::cmd_t     cmd
);

  logic [15:0] exp_seq_r, exp_seq_nxt;
  logic        skip_r, skip_nxt;
  logic        frag_open_r, frag_open_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  ref_bits_r, ref_bits_nxt;
  logic        frag_end_r, frag_end_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  size_hi_r, size_hi_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [1:0]  ferr_r, ferr_nxt;

  // Classify the byte and work out the packet state that follows
  always_comb begin
    logic [7:0]  b;
    logic [4:0]  nal_type;
    logic [15:0] dec;
    b            = in_data.payload_byte;
    nal_type     = b[4:0];
    dec          = remain_r;
    exp_seq_nxt  = exp_seq_r;
    skip_nxt     = skip_r;
    frag_open_nxt = frag_open_r;
    kind_nxt     = kind_r;
    pos_nxt      = pos_r;
    ref_bits_nxt = ref_bits_r;
    frag_end_nxt = frag_end_r;
    phase_nxt    = phase_r;
    size_hi_nxt  = size_hi_r;
    remain_nxt   = remain_r;
    ferr_nxt     = ferr_r;
    cmd          = '0;

    // Open a packet: sequence check and state restart
    if (in_data.packet_first) begin
      if (frag_end_nxt) frag_open_nxt = 1'b0;
      frag_end_nxt = 1'b0;
      pos_nxt      = 2'd0;
      phase_nxt    = hnr_pkg::PHASE_SIZE_HI;
      kind_nxt     = hnr_pkg::KIND_SINGLE;
      if (in_data.frame_first) begin
        exp_seq_nxt   = in_data.seq_number;
        frag_open_nxt = 1'b0;
      end
      if (in_data.seq_number < exp_seq_nxt) begin
        skip_nxt = 1'b1;
      end else begin
        skip_nxt = 1'b0;
        if (in_data.seq_number > exp_seq_nxt) frag_open_nxt = 1'b0;
        exp_seq_nxt = in_data.seq_number + 16'd1;
      end
    end

    if (!skip_nxt) begin
      if (pos_nxt == 2'd0) begin
        // Payload header decides the packetization
        if (nal_type == hnr_pkg::TYPE_FU_A) begin
          kind_nxt     = hnr_pkg::KIND_FU;
          ref_bits_nxt = {b[7:5], 5'd0};
        end else begin
          frag_open_nxt = 1'b0;
          if (nal_type == hnr_pkg::TYPE_STAP_A) begin
            kind_nxt  = hnr_pkg::KIND_STAP;
            phase_nxt = hnr_pkg::PHASE_SIZE_HI;
          end else if (nal_type != 5'd0 && nal_type < hnr_pkg::TYPE_STAP_A) begin
            kind_nxt       = hnr_pkg::KIND_SINGLE;
            cmd.start_code = 1'b1;
            cmd.data_valid = 1'b1;
            cmd.data_byte  = b;
          end else begin
            kind_nxt = hnr_pkg::KIND_DROP;
            if (ferr_nxt == hnr_pkg::ERR_NONE) ferr_nxt = hnr_pkg::ERR_TYPE;
          end
        end
      end else if (kind_nxt == hnr_pkg::KIND_FU) begin
        if (pos_nxt == 2'd1) begin
          // FU header: start bit rebuilds the NAL header
          frag_end_nxt = b[6];
          if (b[7]) begin
            cmd.start_code = 1'b1;
            cmd.data_valid = 1'b1;
            cmd.data_byte  = ref_bits_nxt | {3'd0, b[4:0]};
            frag_open_nxt  = 1'b1;
          end
        end else if (frag_open_nxt) begin
          cmd.data_valid = 1'b1;
          cmd.data_byte  = b;
        end
      end else if (kind_nxt == hnr_pkg::KIND_SINGLE) begin
        cmd.data_valid = 1'b1;
        cmd.data_byte  = b;
      end else if (kind_nxt == hnr_pkg::KIND_STAP) begin
        // Walk the aggregation: size field, then NAL bytes
        unique case (phase_nxt)
          hnr_pkg::PHASE_SIZE_HI: begin
            size_hi_nxt = b;
            phase_nxt   = hnr_pkg::PHASE_SIZE_LO;
          end
          hnr_pkg::PHASE_SIZE_LO: begin
            remain_nxt = {size_hi_nxt, b};
            phase_nxt  = hnr_pkg::PHASE_HEADER;
          end
          hnr_pkg::PHASE_HEADER: begin
            cmd.start_code = 1'b1;
            if (remain_nxt == 16'd0) begin
              size_hi_nxt = b;
              phase_nxt   = hnr_pkg::PHASE_SIZE_LO;
            end else begin
              cmd.data_valid = 1'b1;
              cmd.data_byte  = b;
              dec        = remain_nxt - 16'd1;
              remain_nxt = dec;
              phase_nxt  = (dec != 16'd0) ? hnr_pkg::PHASE_BODY : hnr_pkg::PHASE_SIZE_HI;
            end
          end
          default: begin
            cmd.data_valid = 1'b1;
            cmd.data_byte  = b;
            if (remain_nxt != 16'd0) remain_nxt = remain_nxt - 16'd1;
            if (remain_nxt == 16'd0) phase_nxt = hnr_pkg::PHASE_SIZE_HI;
          end
        endcase
      end
      if (pos_nxt != 2'd2) pos_nxt = pos_nxt + 2'd1;

      // Close the packet: overrun check and fragment end
      if (in_data.packet_last) begin
        if (kind_nxt == hnr_pkg::KIND_STAP && phase_nxt == hnr_pkg::PHASE_BODY &&
            ferr_nxt == hnr_pkg::ERR_NONE)
          ferr_nxt = hnr_pkg::ERR_OVERRUN;
        if (frag_end_nxt) frag_open_nxt = 1'b0;
        frag_end_nxt = 1'b0;
      end
    end

    // Report the frame's sticky error
    if (in_data.frame_last) begin
      cmd.frame_done = 1'b1;
      cmd.error_code = ferr_nxt;
      ferr_nxt       = hnr_pkg::ERR_NONE;
    end
  end

  assign cmd_valid = accept && (cmd.start_code || cmd.data_valid || cmd.frame_done);

  // Commit the state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r   <= '0;
      skip_r      <= 1'b0;
      frag_open_r <= 1'b0;
      kind_r      <= hnr_pkg::KIND_SINGLE;
      pos_r       <= '0;
      ref_bits_r  <= '0;
      frag_end_r  <= 1'b0;
      phase_r     <= hnr_pkg::PHASE_SIZE_HI;
      size_hi_r   <= '0;
      remain_r    <= '0;
      ferr_r      <= hnr_pkg::ERR_NONE;
    end else if (accept) begin
      exp_seq_r   <= exp_seq_nxt;
      skip_r      <= skip_nxt;
      frag_open_r <= frag_open_nxt;
      kind_r      <= kind_nxt;
      pos_r       <= pos_nxt;
      ref_bits_r  <= ref_bits_nxt;
      frag_end_r  <= frag_end_nxt;
      phase_r     <= phase_nxt;
      size_hi_r   <= size_hi_nxt;
      remain_r    <= remain_nxt;
      ferr_r      <= ferr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hnr_queue.sv =====
`default_nettype none
module hnr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hnr_pkg::cmd_t push_data,
  input  wire logic          pop,
  output hnr_pkg::cmd_t      head,
  output logic               full,
  output logic               empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hnr_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== hdl/hnr_back.sv =====
`default_nettype none
module hnr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_data,
  input  wire hnr_pkg::cmd_t head,
  input  wire logic          head_valid,
  input  wire logic          out_pop,
  output hnr_pkg::out_t      out_data,
  output logic               head_done
);

  logic       sep_mode_r;
  logic [2:0] step_r, step_nxt;
  logic [2:0] n_sc;
  logic [2:0] last_step;

  // Count start code bytes and the command's last item
  always_comb begin
    if (head.start_code) n_sc = sep_mode_r ? 3'd3 : 3'd4;
    else n_sc = 3'd0;
    last_step = n_sc + {2'd0, head.data_valid} + {2'd0, head.frame_done} - 3'd1;
  end

  // Select the item for the current step
  always_comb begin
    out_data = '0;
    if (step_r < n_sc) begin
      out_data.out_byte = (step_r == n_sc - 3'd1) ? 8'd1 : 8'd0;
    end else if (step_r == n_sc && head.data_valid) begin
      out_data.out_byte = head.data_byte;
    end else begin
      out_data.frame_done = 1'b1;
      out_data.error_code = head.error_code;
    end
  end

  assign head_done = head_valid && out_pop && (step_r == last_step);

  always_comb begin
    step_nxt = step_r;
    if (head_valid && out_pop) step_nxt = head_done ? 3'd0 : step_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      sep_mode_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_we) sep_mode_r <= cfg_data;
    end
  end

endmodule
`default_nettype wire

// ===== test/h264_rtp_nal_reassembler_test.sv =====
`default_nettype none
module h264_rtp_nal_reassembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 1000;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_push;
  logic         in_full;
  hnr_pkg::in_t in_data;
  logic         out_empty;
  logic         out_pop;
  hnr_pkg::out_t out_data;
  logic         cfg_we;
  logic         cfg_data;

  // Shared run control
  bit   idle_on = 1'b1;
  bit   hold_request = 1'b0;
  int   items_sent = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // Packet under construction and frame sequencing
  logic [7:0]  pkt[$];
  logic [15:0] frame_seq;
  bit          frame_started;

  // Predicted stream and depacketizer state
  hnr_pkg::out_t annexb_expected[$];
  hnr_pkg::out_t want;
  logic        short_start_code = 1'b0;
  logic [15:0] next_seq = '0;
  logic        drop_packet = 1'b0;
  logic        fu_open = 1'b0;
  logic [1:0]  pkt_kind = hnr_pkg::KIND_SINGLE;
  logic [1:0]  byte_pos = '0;
  logic [7:0]  fu_nri = '0;
  logic        fu_end_pending = 1'b0;
  logic [1:0]  stap_phase = hnr_pkg::PHASE_SIZE_HI;
  logic [7:0]  stap_len_hi = '0;
  logic [15:0] stap_left = '0;
  logic [1:0]  sticky_err = hnr_pkg::ERR_NONE;

  h264_rtp_nal_reassembler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Queue one stream data byte
  task automatic push_data(input logic [7:0] b);
    annexb_expected.push_back({b, 1'b0, hnr_pkg::ERR_NONE});
  endtask

  // Queue a 3- or 4-byte start code
  task automatic push_start_code();
    if (!short_start_code) push_data(8'h00);
    push_data(8'h00);
    push_data(8'h00);
    push_data(8'h01);
  endtask

  // Keep only the first error of a frame
  task automatic flag_error(input logic [1:0] code);
    if (sticky_err == hnr_pkg::ERR_NONE) sticky_err = code;
  endtask

  // Advance the depacketizer by one payload byte and queue its output
  task automatic depacketize_byte(input hnr_pkg::in_t it);
    logic [7:0] b;
    logic [4:0] nal_type;
    b = it.payload_byte;
    nal_type = b[4:0];
    // Packet start: sequence check and per-packet reset
    if (it.packet_first) begin
      if (fu_end_pending) fu_open = 1'b0;
      fu_end_pending = 1'b0;
      byte_pos = '0;
      stap_phase = hnr_pkg::PHASE_SIZE_HI;
      pkt_kind = hnr_pkg::KIND_SINGLE;
      if (it.frame_first) begin
        next_seq = it.seq_number;
        fu_open = 1'b0;
      end
      if (it.seq_number < next_seq) begin
        drop_packet = 1'b1;
      end else begin
        drop_packet = 1'b0;
        if (it.seq_number > next_seq) fu_open = 1'b0;
        next_seq = it.seq_number + 16'd1;
      end
    end
    if (!drop_packet) begin
      if (byte_pos == 2'd0) begin
        // NAL header or packetization type
        if (nal_type == hnr_pkg::TYPE_FU_A) begin
          pkt_kind = hnr_pkg::KIND_FU;
          fu_nri = b & 8'hE0;
        end else begin
          fu_open = 1'b0;
          if (nal_type == hnr_pkg::TYPE_STAP_A) begin
            pkt_kind = hnr_pkg::KIND_STAP;
            stap_phase = hnr_pkg::PHASE_SIZE_HI;
          end else if (nal_type >= 5'd1 && nal_type < hnr_pkg::TYPE_STAP_A) begin
            pkt_kind = hnr_pkg::KIND_SINGLE;
            push_start_code();
            push_data(b);
          end else begin
            pkt_kind = hnr_pkg::KIND_DROP;
            flag_error(hnr_pkg::ERR_TYPE);
          end
        end
      end else if (pkt_kind == hnr_pkg::KIND_FU) begin
        // FU header rebuilds the NAL header on the start fragment
        if (byte_pos == 2'd1) begin
          fu_end_pending = b[6];
          if (b[7]) begin
            push_start_code();
            push_data(fu_nri | {3'b000, b[4:0]});
            fu_open = 1'b1;
          end
        end else if (fu_open) begin
          push_data(b);
        end
      end else if (pkt_kind == hnr_pkg::KIND_SINGLE) begin
        push_data(b);
      end else if (pkt_kind == hnr_pkg::KIND_STAP) begin
        // Aggregation: size high, size low, NAL header, body
        case (stap_phase)
          hnr_pkg::PHASE_SIZE_HI: begin
            stap_len_hi = b;
            stap_phase = hnr_pkg::PHASE_SIZE_LO;
          end
          hnr_pkg::PHASE_SIZE_LO: begin
            stap_left = {stap_len_hi, b};
            stap_phase = hnr_pkg::PHASE_HEADER;
          end
          hnr_pkg::PHASE_HEADER: begin
            push_start_code();
            if (stap_left == 16'd0) begin
              stap_len_hi = b;
              stap_phase = hnr_pkg::PHASE_SIZE_LO;
            end else begin
              push_data(b);
              stap_left = stap_left - 16'd1;
              stap_phase = (stap_left != 16'd0) ? hnr_pkg::PHASE_BODY
                                                : hnr_pkg::PHASE_SIZE_HI;
            end
          end
          default: begin
            push_data(b);
            if (stap_left != 16'd0) stap_left = stap_left - 16'd1;
            if (stap_left == 16'd0) stap_phase = hnr_pkg::PHASE_SIZE_HI;
          end
        endcase
      end
      if (byte_pos < 2'd2) byte_pos = byte_pos + 2'd1;
      // Packet end: overrun check and FU-A close
      if (it.packet_last) begin
        if (pkt_kind == hnr_pkg::KIND_STAP && stap_phase == hnr_pkg::PHASE_BODY)
          flag_error(hnr_pkg::ERR_OVERRUN);
        if (fu_end_pending) fu_open = 1'b0;
        fu_end_pending = 1'b0;
      end
    end
    // Frame end report
    if (it.frame_last) begin
      annexb_expected.push_back({8'h00, 1'b1, sticky_err});
      sticky_err = hnr_pkg::ERR_NONE;
    end
  endtask

  // Offer one request, hold it until accepted, then predict its output
  task automatic send_item(input hnr_pkg::in_t it);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    depacketize_byte(it);
    items_sent++;
  endtask

  // Send the bytes in pkt as one packet with its marks
  task automatic send_packet(input logic [15:0] seq, input bit ff, input bit fl,
                             input bit nomark);
    hnr_pkg::in_t it;
    foreach (pkt[i]) begin
      it.payload_byte = pkt[i];
      it.seq_number   = (i == 0) ? seq : 16'($urandom);
      it.packet_first = (i == 0) && !nomark;
      it.packet_last  = (i == pkt.size() - 1);
      it.frame_first  = (i == 0) ? ff : 1'($urandom);
      it.frame_last   = fl && (i == pkt.size() - 1);
      send_item(it);
    end
  endtask

  // Send pkt with a mostly consecutive sequence number; sometimes a gap,
  // a late packet, a missing start mark or a mid-frame resync
  task automatic put_packet(input bit fl);
    int r;
    bit ff;
    bit nomark;
    r = $urandom_range(0, 29);
    ff = !frame_started || r == 3;
    nomark = frame_started && r == 2;
    if (frame_started) begin
      if (r == 0) frame_seq = frame_seq + 16'd2;
      else if (r == 1) frame_seq = frame_seq - 16'd1;
      else if (r == 3) frame_seq = 16'($urandom);
    end
    send_packet(frame_seq, ff, fl, nomark);
    frame_seq = frame_seq + 16'd1;
    frame_started = 1'b1;
  endtask

  // One frame of mixed single NAL, STAP-A, FU-A and junk packets
  task automatic random_frame();
    int nal_count;
    int pick;
    int nfrag;
    int len;
    int ending;
    bit last_unit;
    frame_started = 1'b0;
    frame_seq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    nal_count = $urandom_range(1, 4);
    for (int u = 0; u < nal_count; u++) begin
      last_unit = (u == nal_count - 1);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // FU-A run: start fragment, middles, end fragment
        nfrag = $urandom_range(1, 3);
        for (int f = 0; f < nfrag; f++) begin
          pkt = {};
          pkt.push_back({3'($urandom), hnr_pkg::TYPE_FU_A});
          pkt.push_back({f == 0, f == nfrag - 1, 1'($urandom), 5'($urandom)});
          repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
          put_packet(last_unit && f == nfrag - 1);
        end
      end else begin
        pkt = {};
        if (pick < 60) begin
          pkt.push_back({3'($urandom), 5'($urandom_range(1, 23))});
          repeat ($urandom_range(0, 7)) pkt.push_back(8'($urandom));
        end else if (pick < 88) begin
          // STAP-A with small units; rarely a huge size that overruns
          pkt.push_back({3'($urandom), hnr_pkg::TYPE_STAP_A});
          repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 65535);
            pkt.push_back(8'(len >> 8));
            pkt.push_back(8'(len));
            for (int i = 0; i < len && i < 6; i++) pkt.push_back(8'($urandom));
          end
          ending = $urandom_range(0, 9);
          if (ending == 0) repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom));
          else if (ending == 1 && pkt.size() > 1) void'(pkt.pop_back());
        end else begin
          repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
        end
        put_packet(last_unit);
      end
    end
  endtask

  task automatic run_random_items(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) random_frame();
  endtask

  // Drop the request line, drain the expected stream, let the block settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (annexb_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic mode);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    short_start_code = mode;
    cfg_we <= 1'b0;
  endtask

  // Directed packetization cases with four-byte start codes
  task automatic test_packetization_cases();
    write_separator(1'b0);
    // a byte before any packet start mark
    pkt = '{8'h41};
    send_packet(16'h0000, 1'b0, 1'b0, 1'b1);
    // single NAL at the top sequence number, then wrap to zero
    pkt = '{8'h65, 8'hFF, 8'h00};
    send_packet(16'hFFFF, 1'b1, 1'b0, 1'b0);
    // STAP-A with one unit, a zero-size unit and a trailing byte
    pkt = '{8'h18, 8'h00, 8'h01, 8'hE1, 8'h00, 8'h00, 8'h07};
    send_packet(16'h0000, 1'b0, 1'b0, 1'b0);
    // FU-A start and end fragments
    pkt = '{8'h7C, 8'h85, 8'hAA};
    send_packet(16'h0001, 1'b0, 1'b0, 1'b0);
    pkt = '{8'h7C, 8'h45, 8'hBB};
    send_packet(16'h0002, 1'b0, 1'b0, 1'b0);
    // lost fragment after a gap, then a late packet that is skipped
    pkt = '{8'h7C, 8'h05};
    send_packet(16'h0004, 1'b0, 1'b0, 1'b0);
    pkt = '{8'h41, 8'h11};
    send_packet(16'h0003, 1'b0, 1'b0, 1'b0);
    // unknown type 31 reported at frame end
    pkt = '{8'hFF};
    send_packet(16'h0005, 1'b0, 1'b1, 1'b0);
    // STAP-A overrun in a new frame
    pkt = '{8'h18, 8'h00, 8'h05, 8'h33};
    send_packet(16'h0006, 1'b1, 1'b1, 1'b0);
    // type zero
    pkt = '{8'h00};
    send_packet(16'h0007, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_three_byte_start_code();
    write_separator(1'b1);
    idle_on = 1'b1;
    run_random_items(140);
  endtask

  task automatic test_full_rate();
    write_separator(1'b0);
    idle_on = 1'b0;
    run_random_items(90);
    idle_on = 1'b1;
  endtask

  // Stall the result side so the queue fills and in_full rises
  task automatic test_backpressure();
    write_separator(1'b1);
    idle_on = 1'b0;
    hold_request = 1'b1;
    run_random_items(60);
    idle_on = 1'b1;
  endtask

  task automatic test_mixed_idle();
    write_separator(1'b0);
    idle_on = 1'b1;
    run_random_items(90);
  endtask

  // Result side: random pop, long hold-off on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_pop <= !idle_on || $urandom_range(0, 99) >= 20;
    end
  end

  // Compare each popped result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (annexb_expected.size() == 0) begin
        $error("out_data: no result expected, got %h", out_data);
        mismatches++;
      end else begin
        want = annexb_expected.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          mismatches++;
        end
        if (out_data.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, out_data.frame_done);
          mismatches++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_data.error_code);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_push  = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_packetization_cases();
    test_three_byte_start_code();
    test_full_rate();
    test_backpressure();
    test_mixed_idle();

    wait_idle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/hnr_pkg.sv
hdl/hnr_front.sv
hdl/hnr_queue.sv
hdl/hnr_back.sv
hdl/h264_rtp_nal_reassembler.sv
test/h264_rtp_nal_reassembler_test.sv
